// ===== rtl/text_line_folder_core_defines.svh =====
// Assertion helpers for the line folder checker.
`ifndef TEXT_LINE_FOLDER_CORE_DEFINES_SVH
`define TEXT_LINE_FOLDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlf_pkg.sv =====
package tlf_pkg;

    localparam int BYTE_W         = 8;
    localparam int COL_W          = 7;
    localparam int MCOL_W         = 6;
    localparam int HOLD_DEPTH_DEF = 64;
    localparam int TAB_STOP_DEF   = 8;

    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;

    localparam logic [MCOL_W-1:0] MAX_COL_RESET = 6'd60;

    // source of an output word
    typedef enum logic [1:0] {
        SRC_CH  = 2'd0,
        SRC_NL  = 2'd1,
        SRC_RAM = 2'd2
    } t_src;

    typedef struct packed {
        logic load;       // latch input word and work out its plan
        logic start_pre;  // begin flushing the old held bytes
        logic start_fin;  // begin streaming the held bytes at the end of the word
        logic rd;         // read hold RAM at current index, advance index
        logic wr;         // store the input byte in the hold RAM
        logic emit;       // load the output register
        t_src src;
        logic last;
        logic fin;        // emitted word belongs to the final stream
    } t_dp_cmd;

    typedef struct packed {
        logic pre;        // old held bytes go out first
        logic wr;         // input byte is held
        logic nl_ins;     // fold: newline goes in
        logic emit_ch;    // input byte goes straight out
        logic stream;     // held bytes go out at the end
        logic more;       // stream has bytes left to read
        logic out_free;   // output register can take a word
    } t_dp_status;

endpackage

// ===== rtl/tlf_ram.sv =====
module tlf_ram #(
    parameter int WIDTH = tlf_pkg::BYTE_W,
    parameter int DEPTH = tlf_pkg::HOLD_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tlf_datapath.sv =====
module tlf_datapath #(
    parameter int HOLD_DEPTH = tlf_pkg::HOLD_DEPTH_DEF,
    parameter int TAB_STOP   = tlf_pkg::TAB_STOP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tlf_pkg::BYTE_W-1:0]    i_ch,
    input  logic                          i_end,
    input  logic                          i_cfg_we,
    input  logic [tlf_pkg::MCOL_W-1:0]    i_cfg_data,
    input  tlf_pkg::t_dp_cmd              i_cmd,
    output tlf_pkg::t_dp_status           o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tlf_pkg::BYTE_W-1:0]    o_out_char,
    output logic                          o_out_last
);

    import tlf_pkg::*;

    localparam int AW = $clog2(HOLD_DEPTH);
    localparam int HW = $clog2(HOLD_DEPTH + 1);
    localparam int PW = $clog2(TAB_STOP);

    // column plus its offset from the last tab stop
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [PW-1:0]    ph;
    } t_pos;

    function automatic t_pos advance(t_pos p, logic [BYTE_W-1:0] c);
        t_pos q;
        if (c == CH_TAB) begin
            q.col = p.col + (COL_W'(TAB_STOP) - COL_W'(p.ph));
            q.ph  = '0;
        end else begin
            q.col = p.col + COL_W'(1);
            q.ph  = (p.ph == PW'(TAB_STOP - 1)) ? '0 : p.ph + PW'(1);
        end
        return q;
    endfunction

    logic [MCOL_W-1:0] r_max_col, n_max_col;
    t_pos              r_pos, n_pos;
    logic              r_in_word, n_in_word;
    logic              r_cand, n_cand;
    logic [HW-1:0]     r_held, n_held;
    logic [BYTE_W-1:0] r_ch, n_ch;
    logic              r_pre, n_pre;
    logic              r_wr, n_wr;
    logic              r_nl_ins, n_nl_ins;
    logic              r_emit_ch, n_emit_ch;
    logic              r_stream, n_stream;
    logic              r_recomp, n_recomp;
    logic [HW-1:0]     r_pre_len, n_pre_len;
    logic [HW-1:0]     r_fin_len, n_fin_len;
    logic [HW-1:0]     r_idx, n_idx;
    logic [HW-1:0]     r_len, n_len;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;

    logic              is_nl, blank, brk, cand1, full, direct, pre, fold, stream;
    logic [HW-1:0]     h2;
    t_pos              adv, adv0;
    logic [BYTE_W-1:0] ram_rdata;
    logic [AW-1:0]     wr_addr;

    assign is_nl  = (i_ch == CH_NEWLINE);
    assign blank  = (i_ch == CH_TAB) | is_nl | (i_ch == CH_SPACE);
    assign brk    = r_in_word & blank;
    assign cand1  = r_cand | brk;
    assign full   = cand1 & ~brk & (r_held >= HW'(HOLD_DEPTH));
    assign direct = ~cand1 | full;
    assign pre    = (brk & (r_held != '0)) | full;
    assign h2     = direct ? '0 : (brk ? HW'(1) : r_held + HW'(1));
    assign adv    = advance(r_pos, i_ch);
    assign adv0   = advance('0, i_ch);
    assign fold   = ~is_nl & (adv.col >= COL_W'(r_max_col));
    assign stream = ~direct & (is_nl | fold | i_end);

    assign wr_addr = AW'(r_fin_len - HW'(1));

    tlf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HOLD_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (wr_addr),
        .i_wdata (r_ch),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_max_col   = r_max_col;
        n_pos       = r_pos;
        n_in_word   = r_in_word;
        n_cand      = r_cand;
        n_held      = r_held;
        n_ch        = r_ch;
        n_pre       = r_pre;
        n_wr        = r_wr;
        n_nl_ins    = r_nl_ins;
        n_emit_ch   = r_emit_ch;
        n_stream    = r_stream;
        n_recomp    = r_recomp;
        n_pre_len   = r_pre_len;
        n_fin_len   = r_fin_len;
        n_idx       = r_idx;
        n_len       = r_len;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (i_cfg_we) begin
            n_max_col = i_cfg_data;
        end

        if (i_cmd.load) begin
            n_ch      = i_ch;
            n_pre     = pre;
            n_pre_len = r_held;
            n_fin_len = h2;
            n_wr      = ~direct;
            n_nl_ins  = fold;
            n_emit_ch = direct;
            n_stream  = stream;
            n_recomp  = fold & ~direct;
            if (is_nl) begin
                n_pos     = '0;
                n_in_word = 1'b0;
                n_cand    = 1'b0;
                n_held    = '0;
            end else if (fold) begin
                // column is rebuilt over the held bytes as they go out
                n_pos     = direct ? adv0 : '0;
                n_in_word = 1'b0;
                n_cand    = 1'b0;
                n_held    = '0;
            end else begin
                n_pos     = adv;
                n_in_word = ~blank;
                n_cand    = ~i_end & cand1 & ~full;
                n_held    = i_end ? '0 : h2;
            end
        end

        if (i_cmd.start_pre) begin
            n_idx = '0;
            n_len = r_pre_len;
        end
        if (i_cmd.start_fin) begin
            n_idx = '0;
            n_len = r_fin_len;
        end
        if (i_cmd.rd) begin
            n_idx = r_idx + HW'(1);
        end

        if (i_cmd.emit & i_cmd.fin & r_recomp) begin
            n_pos = advance(r_pos, ram_rdata);
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_last  = i_cmd.last;
            case (i_cmd.src)
                SRC_CH:  n_out_char = r_ch;
                SRC_NL:  n_out_char = CH_NEWLINE;
                SRC_RAM: n_out_char = ram_rdata;
                default: n_out_char = r_ch;
            endcase
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_col   <= MAX_COL_RESET;
            r_pos       <= '0;
            r_in_word   <= 1'b0;
            r_cand      <= 1'b0;
            r_held      <= '0;
            r_pre       <= 1'b0;
            r_wr        <= 1'b0;
            r_nl_ins    <= 1'b0;
            r_emit_ch   <= 1'b0;
            r_stream    <= 1'b0;
            r_recomp    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_max_col   <= n_max_col;
            r_pos       <= n_pos;
            r_in_word   <= n_in_word;
            r_cand      <= n_cand;
            r_held      <= n_held;
            r_pre       <= n_pre;
            r_wr        <= n_wr;
            r_nl_ins    <= n_nl_ins;
            r_emit_ch   <= n_emit_ch;
            r_stream    <= n_stream;
            r_recomp    <= n_recomp;
            r_out_valid <= n_out_valid;
        end
        r_ch       <= n_ch;
        r_pre_len  <= n_pre_len;
        r_fin_len  <= n_fin_len;
        r_idx      <= n_idx;
        r_len      <= n_len;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_status.pre      = r_pre;
    assign o_status.wr       = r_wr;
    assign o_status.nl_ins   = r_nl_ins;
    assign o_status.emit_ch  = r_emit_ch;
    assign o_status.stream   = r_stream;
    assign o_status.more     = (r_idx != r_len);
    assign o_status.out_free = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// ===== rtl/tlf_ctrl.sv =====
module tlf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tlf_pkg::t_dp_status  i_status,
    output tlf_pkg::t_dp_cmd     o_cmd
);

    import tlf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_PRE_RD   = 9'b000000100,
        S_PRE_OUT  = 9'b000001000,
        S_WRITE    = 9'b000010000,
        S_NL       = 9'b000100000,
        S_CH       = 9'b001000000,
        S_FIN_RD   = 9'b010000000,
        S_FIN_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.src  = SRC_CH;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.pre) begin
                    o_cmd.start_pre = 1'b1;
                    n_state         = S_PRE_RD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_PRE_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_PRE_OUT;
            end
            S_PRE_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_RAM;
                    o_cmd.last = ~i_status.more & ~i_status.emit_ch & ~i_status.stream;
                    if (i_status.more) begin
                        o_cmd.rd = 1'b1;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.wr = i_status.wr;
                if (i_status.nl_ins) begin
                    n_state = S_NL;
                end else if (i_status.emit_ch) begin
                    n_state = S_CH;
                end else if (i_status.stream) begin
                    o_cmd.start_fin = 1'b1;
                    n_state         = S_FIN_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_NL: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_NL;
                    if (i_status.emit_ch) begin
                        n_state = S_CH;
                    end else begin
                        o_cmd.start_fin = 1'b1;
                        n_state         = S_FIN_RD;
                    end
                end
            end
            S_CH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_CH;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FIN_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_FIN_OUT;
            end
            S_FIN_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_RAM;
                    o_cmd.fin  = 1'b1;
                    o_cmd.last = ~i_status.more;
                    if (i_status.more) begin
                        o_cmd.rd = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/text_line_folder_core.sv =====
// Channel      Dir  Fields (low bit first)            Takes a word when
// s_axis       in   tdata: ch[7:0]; tlast: end_of_text  tvalid & tready
// m_axis       out  tdata: out_char[7:0]; tlast: last   tvalid & tready
// cfg          in   data: max_column[5:0]               valid & ready
//
// A straight-out byte steps through accept, plan, store and emit; a byte only held skips the emit.
// Flushing held bytes first adds a read ahead of their emits, an inserted newline adds its emit,
// and streaming held bytes after it adds a read and takes the place of the emit; the single read
// port of the hold RAM sets that pace, one byte per cycle while m_axis does not stall.
// i_rst_n is synchronous, active low; the hold RAM is not cleared, only its
// fill count is, so no sweep follows reset.
// A stalled m_axis holds the sequencer at its next word; s_axis is ready only between bytes.
module text_line_folder_core #(
    parameter int HOLD_DEPTH = tlf_pkg::HOLD_DEPTH_DEF,
    parameter int TAB_STOP   = tlf_pkg::TAB_STOP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input text bytes
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [tlf_pkg::BYTE_W-1:0]  i_s_axis_tdata,   // ch[7:0]
    input  logic                        i_s_axis_tlast,   // end_of_text
    // folded text out
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [tlf_pkg::BYTE_W-1:0]  o_m_axis_tdata,   // out_char[7:0]
    output logic                        o_m_axis_tlast,   // last word for this input byte
    // fold column register
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tlf_pkg::MCOL_W-1:0]  i_cfg_data
);

    import tlf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // register writes land at once; the user must only write while idle; not enforced by the block
    assign o_cfg_ready = 1'b1;

    // sequencer: walks each byte through flush, store, fold and emit steps
    tlf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // column tracking, break candidate, hold RAM and output word register
    tlf_datapath #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .TAB_STOP   (TAB_STOP)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ch        (i_s_axis_tdata),
        .i_end       (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_char  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

// ===== rtl/tlf_checker.sv =====
`include "text_line_folder_core_defines.svh"

module tlf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic [tlf_pkg::BYTE_W-1:0]  i_s_axis_tdata,
    input logic                        i_s_axis_tlast,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [tlf_pkg::BYTE_W-1:0]  o_m_axis_tdata,
    input logic                        o_m_axis_tlast,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready,
    input logic [tlf_pkg::MCOL_W-1:0]  i_cfg_data
);

    `TLF_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "output word changed while stalled")
    `TLF_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken again straight after a byte")
    `TLF_ASSERT_NOW(a_idle_word_last, o_s_axis_tready && o_m_axis_tvalid, o_m_axis_tlast, "ready for a byte with a non-final word pending")

endmodule

bind text_line_folder_core tlf_checker u_tlf_checker (.*);
